/* rtl/gcrft_pkg.sv */
// Shared constants and codes for the GC run finder with window tally.
// No dependencies; compile first.
package gcrft_pkg;

    localparam int DEF_MAX_WINDOWS = 1024;

    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int SEL_W    = 10;
    localparam int WS_W     = 24;
    localparam int POS_W    = 32;
    localparam int END_W    = 33;
    localparam int CNT_W    = 24;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_BASE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Result kinds
    localparam logic RES_RUN    = 1'b0;
    localparam logic RES_WINDOW = 1'b1;

    // Base letters
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;

    localparam logic [WS_W-1:0]  WS_RESET  = 24'd1000;
    localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFF_FFFF;
    localparam logic [POS_W-1:0] POS_MAX   = 32'hFFFF_FFFF;
    localparam logic [END_W-1:0] END_MAX   = 33'h1_0000_0000;

endpackage

/* rtl/gcrft_if.sv */
// Request and result channel interfaces for the GC run finder.
// Depends on gcrft_pkg for field widths.
interface gcrft_in_if;
    logic                             valid;
    logic                             ready;
    logic [gcrft_pkg::KIND_W-1:0]     kind;
    logic [gcrft_pkg::CHAR_W-1:0]     base_char;
    logic [gcrft_pkg::SEL_W-1:0]      window_select;

    modport source (output valid, output kind, output base_char, output window_select,
                    input ready);
    modport sink   (input valid, input kind, input base_char, input window_select,
                    output ready);
endinterface

interface gcrft_out_if;
    logic                             valid;
    logic                             ready;
    logic                             result_kind;
    logic [gcrft_pkg::POS_W-1:0]      span_begin;
    logic [gcrft_pkg::END_W-1:0]      span_end;
    logic [gcrft_pkg::CNT_W-1:0]      gc_count;
    logic                             lost_flag;

    modport source (output valid, output result_kind, output span_begin, output span_end,
                    output gc_count, output lost_flag, input ready);
    modport sink   (input valid, input result_kind, input span_begin, input span_end,
                    input gc_count, input lost_flag, output ready);
endinterface

/* rtl/gcrft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcrft_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gc_run_finder_window_tally_unit.sv */
// Top level of the GC run finder with per-window tally; uses gcrft_pkg,
// the channel interfaces in gcrft_if and the window count RAM gcrft_ram.
//
// Bases stream in one request at a time; maximal runs of C/G letters holding
// at least one C and one G are reported as half-open intervals when they end
// (non-C/G base or end of sequence). A run that closes is divided by the
// window size in a bit-serial restoring divider, then walked window by
// window with read-modify-write on the count RAM. A window read takes the
// request, reads and multiplies for the bounds, clears the entry and loads
// the output register. Results then wait in an output register, and a result
// still waiting there holds the unit until it is taken. After reset the
// count RAM is swept to zero, one entry a cycle, and no request is taken
// meanwhile. Write the window size only while no request is in flight: a
// walk reads it on every cycle.
module gc_run_finder_window_tally_unit #(
    parameter int MAX_WINDOWS = gcrft_pkg::DEF_MAX_WINDOWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gcrft_pkg::WS_W-1:0]  i_cfg_wdata,
    gcrft_in_if.sink                    i_in,
    gcrft_out_if.source                 o_out
);

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOWS - 1);
    localparam logic [32:0]   MAX_WIN33 = 33'(MAX_WINDOWS);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_DIV_FIN,
        ST_WIN_CHK,
        ST_WIN_UPD,
        ST_RD_REQ,
        ST_RD_FIN,
        ST_DONE
    } t_state;

    t_state r_state;

    // Configuration and run tracking
    logic [23:0] r_ws;
    logic        r_seen_c, r_seen_g, r_run_open, r_lost_seen;
    logic [31:0] r_run_start, r_position;
    logic [32:0] r_run_stop;

    // Working registers of the sequencer
    logic [31:0]  r_s;        // run start
    logic [32:0]  r_e;        // run end, exclusive
    logic [31:0]  r_quo;      // dividend shifting out, quotient shifting in; later window index
    logic [23:0]  r_rem;
    logic [4:0]   r_cnt;
    logic [33:0]  r_lo;       // low bound of the current window
    logic [9:0]   r_sel;
    logic [AW-1:0] r_clr_addr;

    // Pending result
    logic         r_res_kind;
    logic [31:0]  r_res_begin;
    logic [32:0]  r_res_end;
    logic [23:0]  r_res_count;
    logic         r_res_lost;

    // Output register
    logic         r_out_valid;
    logic         r_out_kind;
    logic [31:0]  r_out_begin;
    logic [32:0]  r_out_end;
    logic [23:0]  r_out_count;
    logic         r_out_lost;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata, ram_rdata;

    gcrft_ram #(
        .WIDTH  (gcrft_pkg::CNT_W),
        .DEPTH  (MAX_WINDOWS),
        .ADDR_W (AW)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Combinational helpers
    logic [23:0] ws_eff;
    logic        in_fire, is_c, is_g, run_qual;
    logic [24:0] div_trial;
    logic        div_ge;
    logic [33:0] win_hi, ov_a, ov_b;
    logic [24:0] ov_len;
    logic [25:0] upd_sum;
    logic [23:0] upd_sat;
    logic        walk_last, quo_out, sel_in;
    logic [33:0] n_lo;
    logic        out_load;

    // A window size of zero behaves as one
    assign ws_eff   = (r_ws == '0) ? 24'd1 : r_ws;
    assign in_fire  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign is_c     = (i_in.base_char == gcrft_pkg::CH_C_UP) ||
                      (i_in.base_char == gcrft_pkg::CH_C_LO);
    assign is_g     = (i_in.base_char == gcrft_pkg::CH_G_UP) ||
                      (i_in.base_char == gcrft_pkg::CH_G_LO);
    assign run_qual = r_seen_c && r_seen_g;

    // One step of restoring division
    assign div_trial = {r_rem, r_quo[31]};
    assign div_ge    = (div_trial >= {1'b0, ws_eff});

    // Overlap of the run with the current window
    assign win_hi  = r_lo + 34'(ws_eff);
    assign ov_b    = ({1'b0, r_e} < win_hi) ? {1'b0, r_e} : win_hi;
    assign ov_a    = ({2'b0, r_s} > r_lo) ? {2'b0, r_s} : r_lo;
    assign ov_len  = 25'(ov_b - ov_a);
    assign upd_sum = {2'b0, ram_rdata} + {1'b0, ov_len};
    assign upd_sat = (upd_sum > {2'b0, gcrft_pkg::COUNT_MAX}) ? gcrft_pkg::COUNT_MAX
                                                            : upd_sum[23:0];
    assign walk_last = (win_hi >= {1'b0, r_e});
    assign quo_out   = ({1'b0, r_quo} >= MAX_WIN33);
    assign sel_in    = (33'(r_sel) < MAX_WIN33);
    assign n_lo      = {24'b0, r_sel} * {10'b0, ws_eff};

    // Load the output register once it is free or being emptied
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    // RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_quo);
        ram_wdata = '0;
        ram_raddr = AW'(r_quo);
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            ST_WIN_UPD: begin
                ram_we    = 1'b1;
                ram_wdata = upd_sat;
            end
            ST_RD_REQ: begin
                ram_raddr = AW'(r_sel);
            end
            ST_RD_FIN: begin
                ram_we    = sel_in;
                ram_waddr = AW'(r_sel);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ws        <= gcrft_pkg::WS_RESET;
            r_seen_c    <= 1'b0;
            r_seen_g    <= 1'b0;
            r_run_open  <= 1'b0;
            r_lost_seen <= 1'b0;
            r_run_start <= '0;
            r_run_stop  <= '0;
            r_position  <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws <= i_cfg_wdata;
            end
            // Drop the result once taken, unless a new one takes its place
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end

                ST_IDLE: begin
                    if (in_fire) begin
                        case (i_in.kind)
                            gcrft_pkg::KIND_BASE: begin
                                if (is_c || is_g) begin
                                    if (is_c) r_seen_c <= 1'b1;
                                    if (is_g) r_seen_g <= 1'b1;
                                    if (!r_run_open) r_run_start <= r_position;
                                    r_run_open <= 1'b1;
                                    r_run_stop <= {1'b0, r_position} + 33'd1;
                                end else begin
                                    r_seen_c   <= 1'b0;
                                    r_seen_g   <= 1'b0;
                                    r_run_open <= 1'b0;
                                    if (run_qual) begin
                                        r_s     <= r_run_start;
                                        r_e     <= r_run_stop;
                                        r_quo   <= r_run_start;
                                        r_rem   <= '0;
                                        r_cnt   <= '0;
                                        r_state <= ST_DIV;
                                    end
                                end
                                // Hold the position at its ceiling
                                if (r_position != gcrft_pkg::POS_MAX) begin
                                    r_position <= r_position + 32'd1;
                                end
                            end
                            gcrft_pkg::KIND_EOS: begin
                                r_seen_c    <= 1'b0;
                                r_seen_g    <= 1'b0;
                                r_run_open  <= 1'b0;
                                r_run_start <= '0;
                                r_run_stop  <= '0;
                                r_position  <= '0;
                                if (run_qual) begin
                                    r_s     <= r_run_start;
                                    r_e     <= r_run_stop;
                                    r_quo   <= r_run_start;
                                    r_rem   <= '0;
                                    r_cnt   <= '0;
                                    r_state <= ST_DIV;
                                end
                            end
                            gcrft_pkg::KIND_READ: begin
                                r_sel   <= i_in.window_select;
                                r_state <= ST_RD_REQ;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // Find the first window index and offset, one bit a cycle
                ST_DIV: begin
                    r_rem <= div_ge ? 24'(div_trial - {1'b0, ws_eff}) : div_trial[23:0];
                    r_quo <= {r_quo[30:0], div_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= ST_DIV_FIN;
                    end
                end

                ST_DIV_FIN: begin
                    r_lo    <= {2'b0, r_s} - {10'b0, r_rem};
                    r_state <= ST_WIN_CHK;
                end

                // Stop at the end of the store; the rest of the run is lost
                ST_WIN_CHK: begin
                    if (quo_out) begin
                        r_lost_seen <= 1'b1;
                        r_res_lost  <= 1'b1;
                        r_res_kind  <= gcrft_pkg::RES_RUN;
                        r_res_begin <= r_s;
                        r_res_end   <= r_e;
                        r_res_count <= '0;
                        r_state     <= ST_DONE;
                    end else begin
                        r_state <= ST_WIN_UPD;
                    end
                end

                ST_WIN_UPD: begin
                    if (walk_last) begin
                        r_res_lost  <= 1'b0;
                        r_res_kind  <= gcrft_pkg::RES_RUN;
                        r_res_begin <= r_s;
                        r_res_end   <= r_e;
                        r_res_count <= '0;
                        r_state     <= ST_DONE;
                    end else begin
                        r_lo    <= win_hi;
                        r_quo   <= r_quo + 32'd1;
                        r_state <= ST_WIN_CHK;
                    end
                end

                ST_RD_REQ: begin
                    r_lo    <= n_lo;
                    r_state <= ST_RD_FIN;
                end

                // Report bounds and count, clear the entry
                ST_RD_FIN: begin
                    r_res_kind  <= gcrft_pkg::RES_WINDOW;
                    r_res_begin <= (r_lo > {2'b0, gcrft_pkg::POS_MAX}) ? gcrft_pkg::POS_MAX
                                                                     : r_lo[31:0];
                    r_res_end   <= (win_hi > {1'b0, gcrft_pkg::END_MAX}) ? gcrft_pkg::END_MAX
                                                                       : win_hi[32:0];
                    r_res_count <= sel_in ? ram_rdata : '0;
                    r_res_lost  <= r_lost_seen;
                    r_state     <= ST_DONE;
                end

                ST_DONE: begin
                    if (out_load) begin
                        r_out_kind  <= r_res_kind;
                        r_out_begin <= r_res_begin;
                        r_out_end   <= r_res_end;
                        r_out_count <= r_res_count;
                        r_out_lost  <= r_res_lost;
                        r_state     <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out_kind;
    assign o_out.span_begin  = r_out_begin;
    assign o_out.span_end    = r_out_end;
    assign o_out.gc_count    = r_out_count;
    assign o_out.lost_flag   = r_out_lost;

endmodule
